// ----- hw/rtl/ckvs_pkg.sv -----
// Shared types and constants for the coordinate key/value table.
package ckvs_pkg;

  localparam int unsigned CKVS_ENTRIES    = 256;
  localparam int unsigned CKVS_COORD_BITS = 10;
  localparam int unsigned CKVS_GROUP_SIZE = 16;
  localparam int unsigned CKVS_STATUS_W   = 3;

  localparam logic OP_SET    = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  typedef enum logic [CKVS_STATUS_W-1:0] {
    STAT_INSERTED  = 3'd0,
    STAT_UPDATED   = 3'd1,
    STAT_FULL      = 3'd2,
    STAT_FOUND     = 3'd3,
    STAT_NOT_FOUND = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MATCH,
    ST_REDUCE,
    ST_RESOLVE,
    ST_ACCESS,
    ST_RESPOND
  } state_t;

  typedef struct packed {
    logic load;
    logic match;
    logic reduce;
    logic resolve;
    logic access;
    logic respond;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_status_t;

endpackage

// ----- hw/rtl/ckvs_ctrl.sv -----
// Sequencing state machine for one table transaction at a time.
module ckvs_ctrl
  import ckvs_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t dp_stat,
  output ctrl_cmd_t  cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_MATCH;
        end
      end
      ST_MATCH:   state_next = ST_REDUCE;
      ST_REDUCE:  state_next = ST_RESOLVE;
      ST_RESOLVE: state_next = ST_ACCESS;
      ST_ACCESS:  state_next = ST_RESPOND;
      ST_RESPOND: begin
        // hold until the output register can take the result
        if (dp_stat.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready    = 1'b0;
    cmd         = '0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_MATCH:   cmd.match   = 1'b1;
      ST_REDUCE:  cmd.reduce  = 1'b1;
      ST_RESOLVE: cmd.resolve = 1'b1;
      ST_ACCESS:  cmd.access  = 1'b1;
      ST_RESPOND: cmd.respond = dp_stat.out_free;
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

// ----- hw/rtl/ckvs_datapath.sv -----
// Key registers with parallel compare, value memory and result register.
module ckvs_datapath
  import ckvs_pkg::*;
#(
  parameter int unsigned ENTRIES    = CKVS_ENTRIES,
  parameter int unsigned COORD_BITS = CKVS_COORD_BITS,
  localparam int unsigned KEY_W     = 2 * COORD_BITS
)
(
  input  logic                  clk,
  input  logic                  rst,
  input  ctrl_cmd_t             cmd,
  output dp_status_t            dp_stat,
  input  logic                  in_op,
  input  logic [COORD_BITS-1:0] in_key_row,
  input  logic [COORD_BITS-1:0] in_key_col,
  input  logic [COORD_BITS-1:0] in_value_row,
  input  logic [COORD_BITS-1:0] in_value_col,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [CKVS_STATUS_W-1:0] out_status,
  output logic [COORD_BITS-1:0] out_row,
  output logic [COORD_BITS-1:0] out_col
);

  localparam int unsigned IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CNT_W   = $clog2(ENTRIES + 1);
  localparam int unsigned NGROUPS = (ENTRIES + CKVS_GROUP_SIZE - 1) / CKVS_GROUP_SIZE;

  // request
  logic             req_op;
  logic [KEY_W-1:0] req_key;
  logic [KEY_W-1:0] req_val;

  // table
  logic [KEY_W-1:0] key_reg [ENTRIES];
  logic [KEY_W-1:0] value_mem [ENTRIES];
  logic [CNT_W-1:0] count;

  // search pipeline
  logic [ENTRIES-1:0] match_vec;
  logic [ENTRIES-1:0] match_vec_next;
  logic [NGROUPS-1:0] grp_hit;
  logic [NGROUPS-1:0] grp_hit_next;
  logic [IDX_W-1:0]   grp_idx      [NGROUPS];
  logic [IDX_W-1:0]   grp_idx_next [NGROUPS];
  logic               hit;
  logic               hit_next;
  logic [IDX_W-1:0]   hit_idx;
  logic [IDX_W-1:0]   hit_idx_next;

  // access stage
  logic             full;
  logic             mem_we;
  logic             key_we;
  logic [IDX_W-1:0] wr_addr;
  logic [KEY_W-1:0] rd_data;
  status_t          status;
  status_t          status_next;
  logic             found;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_op  <= in_op;
      req_key <= {in_key_row, in_key_col};
      req_val <= {in_value_row, in_value_col};
    end
  end

  // compare against every written entry
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      match_vec_next[i] = (CNT_W'(i) < count) && (key_reg[i] == req_key);
    end
  end

  // keys are unique, so at most one bit is set and the index is an OR
  always_comb begin
    for (int g = 0; g < NGROUPS; g++) begin
      grp_hit_next[g] = 1'b0;
      grp_idx_next[g] = '0;
      for (int j = 0; j < CKVS_GROUP_SIZE; j++) begin
        if ((g * CKVS_GROUP_SIZE + j) < ENTRIES) begin
          if (match_vec[g * CKVS_GROUP_SIZE + j]) begin
            grp_hit_next[g] = 1'b1;
            grp_idx_next[g] = grp_idx_next[g] | IDX_W'(g * CKVS_GROUP_SIZE + j);
          end
        end
      end
    end
  end

  always_comb begin
    hit_next     = |grp_hit;
    hit_idx_next = '0;
    for (int g = 0; g < NGROUPS; g++) begin
      hit_idx_next = hit_idx_next | grp_idx[g];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.match) begin
      match_vec <= match_vec_next;
    end
    if (cmd.reduce) begin
      grp_hit <= grp_hit_next;
      for (int g = 0; g < NGROUPS; g++) begin
        grp_idx[g] <= grp_idx_next[g];
      end
    end
    if (cmd.resolve) begin
      hit     <= hit_next;
      hit_idx <= hit_idx_next;
    end
  end

  assign full    = (count == CNT_W'(ENTRIES));
  assign wr_addr = hit ? hit_idx : count[IDX_W-1:0];
  assign mem_we  = cmd.access && (req_op == OP_SET) && (hit || !full);
  assign key_we  = cmd.access && (req_op == OP_SET) && !hit && !full;

  always_comb begin
    if (req_op == OP_SET) begin
      if (hit) begin
        status_next = STAT_UPDATED;
      end else if (!full) begin
        status_next = STAT_INSERTED;
      end else begin
        status_next = STAT_FULL;
      end
    end else begin
      status_next = hit ? STAT_FOUND : STAT_NOT_FOUND;
    end
  end

  always_ff @(posedge clk) begin
    if (key_we) begin
      key_reg[wr_addr] <= req_key;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      value_mem[wr_addr] <= req_val;
    end
    if (cmd.access) begin
      rd_data <= value_mem[hit_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (key_we) begin
      count <= count + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.access) begin
      status <= status_next;
      found  <= (req_op == OP_LOOKUP) && hit;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.respond) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.respond) begin
      out_status <= status;
      out_row    <= found ? rd_data[KEY_W-1:COORD_BITS] : '0;
      out_col    <= found ? rd_data[COORD_BITS-1:0] : '0;
    end
  end

  assign dp_stat.out_free = !out_valid || out_ready;

endmodule

// ----- hw/rtl/coordinate_key_value_store.sv -----
// Top level of the associative coordinate key/value table.
//
//  channel  | direction | tdata (low bit up)                          | tuser
//  s_axis   | in        | key_row, key_col, value_row, value_col      | opcode
//  m_axis   | out       | found_row, found_col                        | status
//
// Each transaction passes from acceptance to a loaded result through these
// steps: the request is latched, compared in parallel against the key
// registers, the match vector gets a group and then a final reduction, the
// value memory is accessed, and the output register is loaded once it is free.
// Reset clears the entry count and the handshake; the stores are not cleared.
// A new transaction is accepted while a result waits; the next result is
// held until the output register is taken.
module coordinate_key_value_store
  import ckvs_pkg::*;
#(
  parameter int unsigned ENTRIES    = CKVS_ENTRIES,
  parameter int unsigned COORD_BITS = CKVS_COORD_BITS,
  localparam int unsigned IN_W      = ((4 * COORD_BITS + 7) / 8) * 8,
  localparam int unsigned OUT_W     = ((2 * COORD_BITS + 7) / 8) * 8
)
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  input  logic [IN_W-1:0]          s_axis_tdata,  // key_row, key_col, value_row, value_col
  input  logic [0:0]               s_axis_tuser,  // opcode
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  output logic [OUT_W-1:0]         m_axis_tdata,  // found_row, found_col
  output logic [CKVS_STATUS_W-1:0] m_axis_tuser   // status
);

  ctrl_cmd_t             cmd;
  dp_status_t            dp_stat;
  logic [COORD_BITS-1:0] out_row;
  logic [COORD_BITS-1:0] out_col;

  ckvs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .dp_stat  (dp_stat),
    .cmd      (cmd)
  );

  ckvs_datapath #(
    .ENTRIES    (ENTRIES),
    .COORD_BITS (COORD_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .dp_stat      (dp_stat),
    .in_op        (s_axis_tuser[0]),
    .in_key_row   (s_axis_tdata[COORD_BITS-1:0]),
    .in_key_col   (s_axis_tdata[2*COORD_BITS-1:COORD_BITS]),
    .in_value_row (s_axis_tdata[3*COORD_BITS-1:2*COORD_BITS]),
    .in_value_col (s_axis_tdata[4*COORD_BITS-1:3*COORD_BITS]),
    .out_valid    (m_axis_tvalid),
    .out_ready    (m_axis_tready),
    .out_status   (m_axis_tuser),
    .out_row      (out_row),
    .out_col      (out_col)
  );

  assign m_axis_tdata = OUT_W'({out_col, out_row});

endmodule

// ----- tb/sv/coordinate_key_value_store_test.sv -----
// Self-checking testbench for the associative coordinate key/value table.
module coordinate_key_value_store_test
  import ckvs_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CB         = CKVS_COORD_BITS;
  localparam int IN_W       = ((4 * CB + 7) / 8) * 8;
  localparam int OUT_W      = ((2 * CB + 7) / 8) * 8;
  localparam int POOL_SIZE  = 300;
  localparam int PHASE_ITEMS = 345;
  localparam int HOLD_OFF   = 400;
  localparam int TAIL_WAIT  = 20;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PRINT_CAP  = 100;

  typedef logic [CB-1:0] coord_t;

  // Tracks table contents and the replies still owed by the block.
  class coord_table_scoreboard;
    typedef struct packed {
      status_t status;
      coord_t  row;
      coord_t  col;
    } reply_t;

    logic [2*CB-1:0] key_mem [CKVS_ENTRIES];
    logic [2*CB-1:0] val_mem [CKVS_ENTRIES];
    int unsigned     entry_cnt;
    reply_t          pending_replies [$];
    int              errors;
    int              replies_seen;
    int              status_hits [5];

    function new();
      entry_cnt = 0;
      errors = 0;
      replies_seen = 0;
      foreach (status_hits[i]) status_hits[i] = 0;
    endfunction

    function int outstanding();
      return pending_replies.size();
    endfunction

    // Apply one accepted request to the table copy and queue its reply.
    function void note_request(logic op, coord_t kr, coord_t kc, coord_t vr, coord_t vc);
      logic [2*CB-1:0] key;
      int              hit;
      reply_t          r;
      key = {kr, kc};
      hit = -1;
      for (int i = 0; i < entry_cnt; i++)
        if (hit < 0 && key_mem[i] == key) hit = i;
      r.row = '0;
      r.col = '0;
      if (op == OP_SET) begin
        if (hit >= 0) begin
          val_mem[hit] = {vr, vc};
          r.status = STAT_UPDATED;
        end else if (entry_cnt < CKVS_ENTRIES) begin
          key_mem[entry_cnt] = key;
          val_mem[entry_cnt] = {vr, vc};
          entry_cnt++;
          r.status = STAT_INSERTED;
        end else begin
          r.status = STAT_FULL;
        end
      end else begin
        if (hit >= 0) begin
          r.row = val_mem[hit][2*CB-1:CB];
          r.col = val_mem[hit][CB-1:0];
          r.status = STAT_FOUND;
        end else begin
          r.status = STAT_NOT_FOUND;
        end
      end
      pending_replies.push_back(r);
    endfunction

    task report(string msg);
      if (errors < PRINT_CAP) $display("MISMATCH @%0t: %s", $time, msg);
      errors++;
    endtask

    task check_result(logic [2:0] st, logic [OUT_W-1:0] data);
      reply_t exp;
      coord_t row;
      coord_t col;
      row = data[CB-1:0];
      col = data[2*CB-1:CB];
      if (pending_replies.size() == 0) begin
        report($sformatf("reply status %0d with no request outstanding", st));
      end else begin
        exp = pending_replies.pop_front();
        replies_seen++;
        if (exp.status <= STAT_NOT_FOUND) status_hits[exp.status]++;
        if (st !== exp.status)
          report($sformatf("reply %0d: status %0d, want %0d", replies_seen, st, exp.status));
        if (row !== exp.row)
          report($sformatf("reply %0d: found_row %0d, want %0d", replies_seen, row, exp.row));
        if (col !== exp.col)
          report($sformatf("reply %0d: found_col %0d, want %0d", replies_seen, col, exp.col));
        if (OUT_W > 2 * CB && data[OUT_W-1:2*CB] !== '0)
          report($sformatf("reply %0d: tdata pad bits not zero", replies_seen));
      end
    endtask
  endclass

  logic             clk;
  logic             rst;
  logic             s_axis_tvalid;
  logic             s_axis_tready;
  logic [IN_W-1:0]  s_axis_tdata;
  logic [0:0]       s_axis_tuser;
  logic             m_axis_tvalid;
  logic             m_axis_tready;
  logic [OUT_W-1:0] m_axis_tdata;
  logic [2:0]       m_axis_tuser;

  coord_table_scoreboard sb;
  int                    idle_pct;
  int                    stall_pct;
  int                    hold_cycles;
  int                    cycle_count;
  int                    requests_sent;
  logic [2*CB-1:0]       key_pool [POOL_SIZE];

  coordinate_key_value_store dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Offer one request; hold it until the block takes it.
  task send_request(logic op, coord_t kr, coord_t kc, coord_t vr, coord_t vc);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = op;
    s_axis_tdata  = '0;
    s_axis_tdata[CB-1:0]      = kr;
    s_axis_tdata[2*CB-1:CB]   = kc;
    s_axis_tdata[3*CB-1:2*CB] = vr;
    s_axis_tdata[4*CB-1:3*CB] = vc;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sb.note_request(op, kr, kc, vr, vc);
    requests_sent++;
  endtask

  task send_random();
    logic [2*CB-1:0] key;
    logic            op;
    op  = 1'($urandom_range(1));
    key = ($urandom_range(99) < 80) ? key_pool[$urandom_range(POOL_SIZE-1)]
                                    : (2*CB)'($urandom);
    send_request(op, key[2*CB-1:CB], key[CB-1:0], coord_t'($urandom), coord_t'($urandom));
  endtask

  // Drop valid and wait for every owed reply.
  task drain();
    @(negedge clk);
    s_axis_tvalid = 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        m_axis_tready = 1'b0;
        hold_cycles--;
      end else begin
        m_axis_tready = ($urandom_range(99) >= stall_pct);
      end
    end
  end

  always @(posedge clk)
    if (!rst && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tuser, m_axis_tdata);

  initial begin
    coord_t hi;
    coord_t lo;
    sb            = new();
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = OP_SET;
    idle_pct      = 0;
    stall_pct     = 0;
    hold_cycles   = 0;
    cycle_count   = 0;
    requests_sent = 0;
    hi = '1;
    lo = '0;

    key_pool[0] = {lo, lo};
    key_pool[1] = {hi, hi};
    key_pool[2] = {lo, hi};
    key_pool[3] = {hi, lo};
    for (int i = 4; i < POOL_SIZE; i++) key_pool[i] = (2*CB)'($urandom);

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Empty table, corner coordinates, updates and misses.
    send_request(OP_LOOKUP, lo, lo, hi, hi);
    send_request(OP_LOOKUP, hi, hi, lo, lo);
    send_request(OP_SET,    lo, lo, hi, hi);
    send_request(OP_SET,    hi, hi, lo, lo);
    send_request(OP_SET,    lo, hi, hi, lo);
    send_request(OP_SET,    hi, lo, lo, hi);
    send_request(OP_LOOKUP, lo, lo, lo, lo);
    send_request(OP_LOOKUP, hi, hi, hi, hi);
    send_request(OP_LOOKUP, lo, hi, lo, lo);
    send_request(OP_LOOKUP, hi, lo, lo, lo);
    send_request(OP_SET,    lo, lo, coord_t'('h155), coord_t'('h2aa));
    send_request(OP_LOOKUP, lo, lo, hi, hi);
    send_request(OP_LOOKUP, lo, coord_t'(1), lo, lo);
    send_request(OP_SET,    lo, lo, lo, lo);
    send_request(OP_LOOKUP, lo, lo, hi, hi);
    send_request(OP_SET,    hi, hi, hi, hi);
    send_request(OP_LOOKUP, hi, hi, lo, lo);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 73; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 73; end
        default: begin idle_pct = 11; stall_pct = 11; end
      endcase
      // Back up the output side long enough to stall the input.
      if (ph == 0) hold_cycles = HOLD_OFF;
      for (int n = 0; n < PHASE_ITEMS; n++) send_random();
      drain();
    end

    // Table is full by now: new keys report full, known keys still update.
    idle_pct = 0;
    stall_pct = 0;
    for (int i = 0; i < 30; i++) begin
      send_request(OP_SET, coord_t'($urandom), coord_t'($urandom),
                   coord_t'($urandom), coord_t'($urandom));
      send_random();
    end
    drain();
    repeat (TAIL_WAIT) @(posedge clk);

    $display("Covered %0d requests, %0d entries held; inserted %0d, updated %0d, full %0d,",
             requests_sent, sb.entry_cnt, sb.status_hits[STAT_INSERTED],
             sb.status_hits[STAT_UPDATED], sb.status_hits[STAT_FULL]);
    $display("found %0d, not found %0d, under idle, stall and long back-pressure phases.",
             sb.status_hits[STAT_FOUND], sb.status_hits[STAT_NOT_FOUND]);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
